// ===== design/bpf_pkg.sv =====
`timescale 1ns / 1ps
package bpf_pkg;

    localparam int CoordW  = 24;
    localparam int OutW    = 16;
    localparam int WeightW = 17;
    localparam int QuadSteps  = 16;
    localparam int CubicSteps = 20;
    localparam int StepW   = 5;

    typedef enum logic [2:0] {
        K_MOVE  = 3'd0,
        K_LINE  = 3'd1,
        K_QUAD  = 3'd2,
        K_CUBIC = 3'd3,
        K_CLOSE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture segment beat
        logic mul;        // register weighted products for step r_step + 1
        logic sum;        // register sum
        logic out_load;   // load output register
        logic commit;     // update current point
        logic clr_step;
        logic inc_step;
    } t_cmd;

    typedef struct packed {
        logic [StepW-1:0] step;
        logic             end_flag;
        logic [2:0]       kind;
    } t_sts;

    // weight k (0..2) for step i of a quadratic: n * 65536 / 256 is exact
    function automatic logic [WeightW-1:0] quad_w(input logic [StepW-1:0] i, input int k);
        int ii;
        int jj;
        ii = int'(i);
        jj = QuadSteps - ii;
        unique case (k)
            0: return WeightW'(jj * jj * 256);
            1: return WeightW'(2 * jj * ii * 256);
            2: return WeightW'(ii * ii * 256);
            default: return '0;
        endcase
    endfunction

    // round(n^3 * 65536 / 8000), half up
    function automatic logic [WeightW-1:0] cub_end(input logic [StepW-1:0] n);
        unique case (n)
            5'd0:  return 17'd0;
            5'd1:  return 17'd8;
            5'd2:  return 17'd66;
            5'd3:  return 17'd221;
            5'd4:  return 17'd524;
            5'd5:  return 17'd1024;
            5'd6:  return 17'd1769;
            5'd7:  return 17'd2810;
            5'd8:  return 17'd4194;
            5'd9:  return 17'd5972;
            5'd10: return 17'd8192;
            5'd11: return 17'd10904;
            5'd12: return 17'd14156;
            5'd13: return 17'd17998;
            5'd14: return 17'd22479;
            5'd15: return 17'd27648;
            5'd16: return 17'd33554;
            5'd17: return 17'd40247;
            5'd18: return 17'd47776;
            5'd19: return 17'd56189;
            5'd20: return 17'd65536;
            default: return '0;
        endcase
    endfunction

    // round(3 * (20-n)^2 * n * 65536 / 8000), half up
    function automatic logic [WeightW-1:0] cub_mid(input logic [StepW-1:0] n);
        unique case (n)
            5'd0:  return 17'd0;
            5'd1:  return 17'd8872;
            5'd2:  return 17'd15925;
            5'd3:  return 17'd21307;
            5'd4:  return 17'd25166;
            5'd5:  return 17'd27648;
            5'd6:  return 17'd28901;
            5'd7:  return 17'd29073;
            5'd8:  return 17'd28312;
            5'd9:  return 17'd26763;
            5'd10: return 17'd24576;
            5'd11: return 17'd21897;
            5'd12: return 17'd18874;
            5'd13: return 17'd15655;
            5'd14: return 17'd12386;
            5'd15: return 17'd9216;
            5'd16: return 17'd6291;
            5'd17: return 17'd3760;
            5'd18: return 17'd1769;
            5'd19: return 17'd467;
            5'd20: return 17'd0;
            default: return '0;
        endcase
    endfunction

    // weight k (0..3) for step i of a cubic, mirrored around the midpoint
    function automatic logic [WeightW-1:0] cub_w(input logic [StepW-1:0] i, input int k);
        logic [StepW-1:0] jj;
        jj = StepW'(CubicSteps) - i;
        unique case (k)
            0: return cub_end(jj);
            1: return cub_mid(i);
            2: return cub_mid(jj);
            default: return cub_end(i);
        endcase
    endfunction

endpackage

// ===== design/bezier_path_flattener.sv =====
`timescale 1ns / 1ps
// Path segment flattener.
// Input channel (i_valid/o_ready): one segment beat with kind, up to three
// Q15.8 points and a path-end flag. Output channel (o_valid/i_ready): one
// beat per point, integer x/y and a last-point flag on the segment's final
// beat.
// Move/line: one point, loaded into the output register from the OUT state;
// the next segment can be taken once that load is done.
// Quadratic: 16 points, cubic: 20 points, each point passing through a
// weight multiply, a four-term sum and the output register in the shared
// multiply-add datapath.
// Close and unknown kinds give no point.
// A new segment is taken only once the previous one has issued its last
// point into the output register.
// Reset puts the current point at the origin and empties the output register.
// While the receiver stalls the output beat holds and the next point waits before the output register.
module bezier_path_flattener (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [23:0] i_p1_x,
    input  logic signed [23:0] i_p1_y,
    input  logic signed [23:0] i_p2_x,
    input  logic signed [23:0] i_p2_y,
    input  logic signed [23:0] i_p3_x,
    input  logic signed [23:0] i_p3_y,
    input  logic               i_path_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic               o_last_point
);
    import bpf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_last  (o_last_point)
    );

    bpf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req_type (i_req_type),
        .i_p1_x     (i_p1_x),
        .i_p1_y     (i_p1_y),
        .i_p2_x     (i_p2_x),
        .i_p2_y     (i_p2_y),
        .i_p3_x     (i_p3_x),
        .i_p3_y     (i_p3_y),
        .i_path_end (i_path_end),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("segment taken while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.step <= 5'd20)
        else $error("step count out of range");
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_ready)
        else $error("segment end did not return to idle");
`endif
endmodule

// ===== design/bpf_ctrl.sv =====
`timescale 1ns / 1ps
module bpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  bpf_pkg::t_sts   i_sts,
    output bpf_pkg::t_cmd   o_cmd,
    output logic            o_last
);
    import bpf_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_last, n_last;
    logic   w_curve, w_pt, w_final;
    logic   w_free;

    assign w_curve = (i_sts.kind == K_QUAD) || (i_sts.kind == K_CUBIC);
    assign w_pt    = (i_sts.kind == K_MOVE) || (i_sts.kind == K_LINE);
    assign w_final = (i_sts.kind == K_QUAD) ? (i_sts.step == StepW'(QuadSteps))
                                            : (i_sts.step == StepW'(CubicSteps));
    assign w_free  = !r_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL;
            S_MUL:   n_state = w_curve ? S_SUM : (w_pt ? S_OUT : S_IDLE);
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (w_free) n_state = (w_pt || w_final) ? S_IDLE : S_MUL;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        n_valid = r_valid && !i_ready;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load   = i_valid;
                o_cmd.clr_step = i_valid;
            end
            S_MUL: begin
                o_cmd.mul      = 1'b1;
                o_cmd.inc_step = w_curve;
                o_cmd.commit   = !w_curve && !w_pt;
            end
            S_SUM: o_cmd.sum = 1'b1;
            S_OUT: if (w_free) begin
                o_cmd.out_load = 1'b1;
                n_valid        = 1'b1;
                n_last         = w_pt || w_final;
                o_cmd.commit   = w_pt || w_final;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
endmodule

// ===== design/bpf_dp.sv =====
`timescale 1ns / 1ps
module bpf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpf_pkg::t_cmd                 i_cmd,
    output bpf_pkg::t_sts                 o_sts,
    input  logic [2:0]                    i_req_type,
    input  logic signed [bpf_pkg::CoordW-1:0] i_p1_x,
    input  logic signed [bpf_pkg::CoordW-1:0] i_p1_y,
    input  logic signed [bpf_pkg::CoordW-1:0] i_p2_x,
    input  logic signed [bpf_pkg::CoordW-1:0] i_p2_y,
    input  logic signed [bpf_pkg::CoordW-1:0] i_p3_x,
    input  logic signed [bpf_pkg::CoordW-1:0] i_p3_y,
    input  logic                          i_path_end,
    output logic signed [bpf_pkg::OutW-1:0]   o_out_x,
    output logic signed [bpf_pkg::OutW-1:0]   o_out_y
);
    import bpf_pkg::*;

    localparam int PW = CoordW + WeightW + 1;   // one product
    localparam int SW = PW + 2;                 // sum of four

    logic [2:0]               r_kind;
    logic                     r_end;
    logic signed [CoordW-1:0] r_cx, r_cy, r_p0x, r_p0y;
    logic signed [CoordW-1:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic [StepW-1:0]         r_step;
    logic signed [PW-1:0]     r_px [4];
    logic signed [PW-1:0]     r_py [4];
    logic signed [SW-1:0]     r_sx, r_sy;
    logic signed [OutW-1:0]   r_ox, r_oy;
    logic [WeightW-1:0]       w_w [4];
    logic signed [CoordW-1:0] w_ax [4];
    logic signed [CoordW-1:0] w_ay [4];
    logic [StepW-1:0]         w_i;
    logic signed [CoordW-1:0] w_ex, w_ey;

    assign w_i = r_step + StepW'(1);
    assign w_ax[0] = r_p0x; assign w_ay[0] = r_p0y;
    assign w_ax[1] = r_x1;  assign w_ay[1] = r_y1;
    assign w_ax[2] = r_x2;  assign w_ay[2] = r_y2;
    assign w_ax[3] = r_x3;  assign w_ay[3] = r_y3;

    // select weights for the next step
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_w[k] = (r_kind == K_QUAD) ? quad_w(w_i, k) : cub_w(w_i, k);
        end
    end

    // new current point
    always_comb begin
        priority if (r_end) begin
            w_ex = '0; w_ey = '0;
        end else if (r_kind == K_MOVE || r_kind == K_LINE) begin
            w_ex = r_x1; w_ey = r_y1;
        end else if (r_kind == K_QUAD) begin
            w_ex = r_x2; w_ey = r_y2;
        end else if (r_kind == K_CUBIC) begin
            w_ex = r_x3; w_ey = r_y3;
        end else begin
            w_ex = r_cx; w_ey = r_cy;
        end
    end

    function automatic logic signed [OutW-1:0] sat(input logic signed [SW-1:0] v,
                                                   input int sh);
        logic signed [SW-1:0] q;
        logic signed [SW-1:0] a;
        a = (v < 0) ? v + ((SW'(1) <<< sh) - SW'(1)) : v;
        q = a >>> sh;
        if (q > SW'(32767))       return 16'sh7fff;
        else if (q < -SW'(32768)) return 16'sh8000;
        else                      return q[OutW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cmd.commit) begin
            r_cx <= w_ex;
            r_cy <= w_ey;
        end
    end

    // capture segment, hold payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_end  <= i_path_end;
            r_x1 <= i_p1_x; r_y1 <= i_p1_y;
            r_x2 <= i_p2_x; r_y2 <= i_p2_y;
            r_x3 <= i_p3_x; r_y3 <= i_p3_y;
            r_p0x <= r_cx;  r_p0y <= r_cy;
        end
        if (!i_rst_n) r_step <= '0;
        else if (i_cmd.clr_step) r_step <= '0;
        else if (i_cmd.inc_step) r_step <= w_i;
        if (i_cmd.mul) begin
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= $signed({1'b0, w_w[k]}) * w_ax[k];
                r_py[k] <= $signed({1'b0, w_w[k]}) * w_ay[k];
            end
        end
        if (i_cmd.sum) begin
            r_sx <= SW'(r_px[0]) + SW'(r_px[1]) + SW'(r_px[2]) + SW'(r_px[3]);
            r_sy <= SW'(r_py[0]) + SW'(r_py[1]) + SW'(r_py[2]) + SW'(r_py[3]);
        end
        if (i_cmd.out_load) begin
            if (r_kind == K_MOVE || r_kind == K_LINE) begin
                r_ox <= sat(SW'(r_x1), 8);
                r_oy <= sat(SW'(r_y1), 8);
            end else begin
                r_ox <= sat(r_sx, 24);
                r_oy <= sat(r_sy, 24);
            end
        end
    end

    assign o_sts.step     = r_step;
    assign o_sts.end_flag = r_end;
    assign o_sts.kind     = r_kind;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import bpf_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } t_point;

    // path point predictor and pending-point store
    class path_scoreboard;
        longint cur_x;
        longint cur_y;
        t_point pending[$];
        int     errors;

        function new();
            cur_x = 0;
            cur_y = 0;
            errors = 0;
        endfunction

        function automatic logic signed [15:0] clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function automatic longint bern(longint n, longint d);
            return (n * 65536 + d / 2) / d;
        endfunction

        function automatic void push_pt(longint sx, longint sy, logic lst);
            t_point p;
            p.x = clamp16(sx / 16777216);
            p.y = clamp16(sy / 16777216);
            p.last = lst;
            pending.push_back(p);
        endfunction

        // note one accepted segment beat
        function automatic void note_segment(logic [2:0] kind,
                                             logic signed [23:0] x1, y1, x2, y2, x3, y3,
                                             logic fin);
            longint j, w0, w1, w2, w3;
            t_point p;
            if (kind == K_MOVE || kind == K_LINE) begin
                p.x = clamp16(longint'(x1) / 256);
                p.y = clamp16(longint'(y1) / 256);
                p.last = 1'b1;
                pending.push_back(p);
                cur_x = x1;
                cur_y = y1;
            end else if (kind == K_QUAD) begin
                for (int i = 1; i <= QuadSteps; i++) begin
                    j = QuadSteps - i;
                    w0 = bern(j * j, 256);
                    w1 = bern(2 * j * i, 256);
                    w2 = bern(i * i, 256);
                    push_pt(w0 * cur_x + w1 * x1 + w2 * x2,
                            w0 * cur_y + w1 * y1 + w2 * y2, i == QuadSteps);
                end
                cur_x = x2;
                cur_y = y2;
            end else if (kind == K_CUBIC) begin
                for (int i = 1; i <= CubicSteps; i++) begin
                    j = CubicSteps - i;
                    w0 = bern(j * j * j, 8000);
                    w1 = bern(3 * j * j * i, 8000);
                    w2 = bern(3 * j * i * i, 8000);
                    w3 = bern(i * i * i, 8000);
                    push_pt(w0 * cur_x + w1 * x1 + w2 * x2 + w3 * x3,
                            w0 * cur_y + w1 * y1 + w2 * y2 + w3 * y3, i == CubicSteps);
                end
                cur_x = x3;
                cur_y = y3;
            end
            if (fin) begin
                cur_x = 0;
                cur_y = 0;
            end
        endfunction

        // compare one output beat with the oldest pending point
        function automatic void check_point(logic signed [15:0] x, y, logic lst);
            t_point e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected point x=%0d y=%0d last=%0b", x, y, lst);
                return;
            end
            e = pending.pop_front();
            if (e.x !== x || e.y !== y || e.last !== lst) begin
                errors++;
                if (errors <= 10)
                    $display("point mismatch: exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                             e.x, e.y, e.last, x, y, lst);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_req_type = '0;
    logic signed [23:0] i_p1_x = '0, i_p1_y = '0, i_p2_x = '0, i_p2_y = '0;
    logic signed [23:0] i_p3_x = '0, i_p3_y = '0;
    logic               i_path_end = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_out_x, o_out_y;
    logic               o_last_point;

    path_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;

    always #6 i_clk = ~i_clk;

    bezier_path_flattener i_dut (.*);

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_segment(i_req_type, i_p1_x, i_p1_y, i_p2_x, i_p2_y,
                            i_p3_x, i_p3_y, i_path_end);
        if (i_rst_n && o_valid && i_ready)
            sb.check_point(o_out_x, o_out_y, o_last_point);
    end

    // receiver stalls, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($urandom);
            default: return $signed(24'($urandom_range(40000))) - 24'sd20000;
        endcase
    endfunction

    // offer one segment beat and hold it until taken
    task automatic send_segment(logic [2:0] kind, logic signed [23:0] x1, y1, x2, y2, x3, y3,
                                logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_p1_x <= x1; i_p1_y <= y1;
        i_p2_x <= x2; i_p2_y <= y2;
        i_p3_x <= x3; i_p3_y <= y3;
        i_path_end <= fin;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [2:0] kind;
        if ($urandom_range(9) == 0) kind = 3'($urandom_range(7));
        else kind = 3'($urandom_range(3));
        send_segment(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), $urandom_range(5) == 0);
    endtask

    // drop valid and wait for every expected point
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every kind, extremes, close, unknown kinds, path end
        send_segment(K_MOVE, 24'sh7FFFFF, -24'sh800000, '0, '0, '0, '0, 1'b0);
        send_segment(K_LINE, -24'sd255, 24'sd255, '0, '0, '0, '0, 1'b0);
        send_segment(K_QUAD, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
                     24'sh123456, '0, 1'b0);
        send_segment(K_CUBIC, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000,
                     24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_segment(K_CLOSE, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 1'b0);
        send_segment(K_LINE, 24'sd2560, 24'sd2560, '0, '0, '0, '0, 1'b0);
        send_segment(3'd5, '0, '0, '0, '0, '0, '0, 1'b0);
        send_segment(3'd6, '0, '0, '0, '0, '0, '0, 1'b0);
        send_segment(3'd7, '0, '0, '0, '0, '0, '0, 1'b1);
        send_segment(K_QUAD, 24'sd1000, -24'sd1000, 24'sd5000, 24'sd300, '0, '0, 1'b1);
        send_segment(K_CLOSE, '0, '0, '0, '0, '0, '0, 1'b1);
        send_segment(K_CUBIC, 24'sh555555, -24'sh2AAAAA, 24'shAAAAA, 24'sd0,
                     -24'sd1, 24'sd1, 1'b1);
        send_segment(K_MOVE, -24'sd1, 24'sd1, '0, '0, '0, '0, 1'b1);
        send_segment(K_MOVE, -24'sh800000, 24'sh7FFFFF, '0, '0, '0, '0, 1'b0);

        // long receiver hold-off while segments keep coming
        hold_off = 300;
        for (int k = 0; k < 6; k++) send_random();
        drain();

        // random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 49 : 25) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 49 : 25) : 0;
            for (int k = 0; k < 78; k++) send_random();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
